// ----- rtl/multichannel_frame_ring_buffer_top_defines.svh -----
// Assertion macros for the frame ring buffer checker.
// Expects clk and arst_n in the scope of each use.
`ifndef MULTICHANNEL_FRAME_RING_BUFFER_TOP_DEFINES_SVH
`define MULTICHANNEL_FRAME_RING_BUFFER_TOP_DEFINES_SVH

`define MFRB_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`define MFRB_ASSERT_NEVER(label, cond, msg) \
	`MFRB_ASSERT(label, !(cond), msg)

`endif

// ----- rtl/mfrb_pkg.sv -----
// Shared types and constants for the multichannel frame ring buffer.
// No dependencies; used by the top level and the checker.
package mfrb_pkg;

	localparam int POS_W  = 6;
	localparam int DONE_W = 12;
	localparam logic [DONE_W-1:0] DONE_SAT = 12'd4095;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_PEEK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_BURST
	} state_t;

	typedef struct packed {
		op_t              operation;
		logic [31:0]      sample_0;
		logic [31:0]      sample_1;
		logic             last_in_burst;
		logic [POS_W-1:0] frame_count;
	} item_t;

	typedef struct packed {
		logic [31:0]       out_sample_0;
		logic [31:0]       out_sample_1;
		logic              frame_valid;
		logic              last;
		logic [DONE_W-1:0] frames_done;
		logic [POS_W-1:0]  fill_level;
		logic              is_empty;
		logic              is_full;
	} result_t;

	typedef struct packed {
		logic              zero;
		logic              frame_valid;
		logic              last;
		logic [DONE_W-1:0] done;
		logic [POS_W-1:0]  fill;
		logic              empty;
		logic              full;
	} meta_t;

	function automatic meta_t make_meta(input logic zero, input logic valid, input logic last,
			input logic [DONE_W-1:0] done, input logic [POS_W-1:0] fill,
			input logic [POS_W-1:0] cap);
		meta_t m;
		m.zero        = zero;
		m.frame_valid = valid;
		m.last        = last;
		m.done        = done;
		m.fill        = fill;
		m.empty       = (fill == '0);
		m.full        = (fill == cap);
		return m;
	endfunction

endpackage

// ----- rtl/mfrb_ram.sv -----
// Simple dual-port frame store: one write port, one read port, registered read.
// No dependencies.
module mfrb_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// hold read data unless a new read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/multichannel_frame_ring_buffer_top.sv -----
// Multichannel frame ring buffer top level.
// Depends on mfrb_pkg and mfrb_ram.
//
// channel   handshake                     word
// item      item_valid / item_ready       mfrb_pkg::item_t
// result    result_valid / result_ready   mfrb_pkg::result_t
// config    cfg_write_en (no wait)        capacity_frames, 6 bits
//
// Write, clear and empty read or peek: one result word each.
// Read or peek of N frames: one frame per cycle from the store's read port while not stalled.
// The result register holds under stall; the read port and sequencer freeze with it.
// Asynchronous reset empties the ring and sets capacity to its maximum; no clearing pass.
module multichannel_frame_ring_buffer_top #(
	parameter int CHANNELS    = 2,
	parameter int MAX_FRAMES  = 63,
	parameter int SAMPLE_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [5:0]        cfg_write_data,
	input  logic              item_valid,
	output logic              item_ready,
	input  mfrb_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output mfrb_pkg::result_t result
);

	import mfrb_pkg::*;

	localparam int DEPTH = MAX_FRAMES + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int WIDTH = CHANNELS * SAMPLE_BITS;
	localparam logic [POS_W-1:0] CAP_MAX = POS_W'(MAX_FRAMES);

	state_t            state_q, state_d;
	logic [POS_W-1:0]  cap_q;
	logic [POS_W-1:0]  wr_pos_q, rd_pos_q, cur_q, fill_q, rem_q, done_q;
	logic [DONE_W-1:0] burst_q;
	logic              peek_q;
	logic              result_valid_q;
	meta_t             meta_s1, meta_d;

	logic              adv, accept, fill_ok, burst_step, load;
	logic [POS_W-1:0]  avail, wr_adv, rd_adv, cur_adv, fill_inc, fill_dec;
	logic [DONE_W-1:0] burst_new;
	logic              rd_en, wr_en;
	logic [AW-1:0]     rd_addr;
	logic [WIDTH-1:0]  wdata, rdata;

	assign adv        = !result_valid_q || result_ready;
	assign accept     = item_valid && item_ready;
	assign burst_step = (state_q == ST_BURST) && adv;
	assign load       = accept || burst_step;
	assign fill_ok    = fill_q < cap_q;
	assign avail      = (item.frame_count < fill_q) ? item.frame_count : fill_q;
	assign wr_adv     = (wr_pos_q == cap_q) ? '0 : POS_W'(wr_pos_q + 1'b1);
	assign rd_adv     = (rd_pos_q == cap_q) ? '0 : POS_W'(rd_pos_q + 1'b1);
	assign cur_adv    = (cur_q == cap_q) ? '0 : POS_W'(cur_q + 1'b1);
	assign fill_inc   = POS_W'(fill_q + 1'b1);
	assign fill_dec   = POS_W'(fill_q - 1'b1);
	assign burst_new  = !fill_ok ? burst_q :
	                    (burst_q == DONE_SAT) ? burst_q : DONE_W'(burst_q + 1'b1);
	assign wr_en      = accept && (item.operation == OP_WRITE) && fill_ok;

	always_comb begin
		wdata = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			wdata[c*SAMPLE_BITS +: SAMPLE_BITS] = (c == 0) ? item.sample_0[SAMPLE_BITS-1:0]
			                                               : item.sample_1[SAMPLE_BITS-1:0];
		end
	end

	mfrb_ram #(
		.DEPTH(DEPTH),
		.WIDTH(WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_pos_q[AW-1:0]),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (item.operation == OP_READ || item.operation == OP_PEEK) &&
						avail > POS_W'(1)) begin
					state_d = ST_BURST;
				end
			end
			ST_BURST: begin
				if (adv && rem_q == POS_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		item_ready = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = rd_pos_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				item_ready = adv;
				rd_en      = accept && (item.operation == OP_READ ||
				             item.operation == OP_PEEK) && avail != '0;
			end
			ST_BURST: begin
				rd_en   = adv;
				rd_addr = cur_q[AW-1:0];
			end
			default: ;
		endcase
	end

	always_comb begin
		meta_d = make_meta(1'b1, 1'b0, 1'b1, '0, '0, cap_q);
		if (burst_step) begin
			meta_d = make_meta(1'b0, 1'b1, rem_q == POS_W'(1), DONE_W'(done_q + 1'b1),
			                   peek_q ? fill_q : fill_dec, cap_q);
		end else begin
			case (item.operation)
				OP_WRITE: meta_d = make_meta(1'b1, fill_ok, 1'b1, burst_new,
				                             fill_ok ? fill_inc : fill_q, cap_q);
				OP_CLEAR: meta_d = make_meta(1'b1, 1'b0, 1'b1, '0, '0, cap_q);
				OP_READ, OP_PEEK: begin
					if (avail == '0) begin
						meta_d = make_meta(1'b1, 1'b0, 1'b1, '0, fill_q, cap_q);
					end else begin
						meta_d = make_meta(1'b0, 1'b1, avail == POS_W'(1), DONE_W'(1),
						                   (item.operation == OP_READ) ? fill_dec : fill_q,
						                   cap_q);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			cap_q          <= CAP_MAX;
			wr_pos_q       <= '0;
			rd_pos_q       <= '0;
			cur_q          <= '0;
			fill_q         <= '0;
			rem_q          <= '0;
			done_q         <= '0;
			burst_q        <= '0;
			peek_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (adv) begin
				result_valid_q <= load;
			end
			if (cfg_write_en) begin
				cap_q    <= (cfg_write_data > CAP_MAX) ? CAP_MAX : cfg_write_data;
				wr_pos_q <= '0;
				rd_pos_q <= '0;
				fill_q   <= '0;
				burst_q  <= '0;
			end else if (burst_step) begin
				cur_q  <= cur_adv;
				rem_q  <= POS_W'(rem_q - 1'b1);
				done_q <= POS_W'(done_q + 1'b1);
				if (!peek_q) begin
					rd_pos_q <= cur_adv;
					fill_q   <= fill_dec;
				end
			end else if (accept) begin
				case (item.operation)
					OP_WRITE: begin
						if (fill_ok) begin
							wr_pos_q <= wr_adv;
							fill_q   <= fill_inc;
						end
						burst_q <= item.last_in_burst ? '0 : burst_new;
					end
					OP_CLEAR: begin
						wr_pos_q <= '0;
						rd_pos_q <= '0;
						fill_q   <= '0;
						burst_q  <= '0;
					end
					OP_READ, OP_PEEK: begin
						cur_q  <= rd_adv;
						rem_q  <= POS_W'(avail - 1'b1);
						done_q <= POS_W'(1);
						peek_q <= (item.operation == OP_PEEK);
						if (item.operation == OP_READ && avail != '0) begin
							rd_pos_q <= rd_adv;
							fill_q   <= fill_dec;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && adv) begin
			meta_s1 <= meta_d;
		end
	end

	assign result_valid        = result_valid_q;
	assign result.out_sample_0 = meta_s1.zero ? '0 : 32'(rdata[SAMPLE_BITS-1:0]);
	assign result.out_sample_1 = (CHANNELS >= 2 && !meta_s1.zero) ?
	                             32'(rdata[(CHANNELS-1)*SAMPLE_BITS +: SAMPLE_BITS]) : '0;
	assign result.frame_valid  = meta_s1.frame_valid;
	assign result.last         = meta_s1.last;
	assign result.frames_done  = meta_s1.done;
	assign result.fill_level   = meta_s1.fill;
	assign result.is_empty     = meta_s1.empty;
	assign result.is_full      = meta_s1.full;

endmodule

// ----- rtl/mfrb_checker.sv -----
// Port-level checker for the frame ring buffer, bound to the top level.
// Depends on mfrb_pkg and the assertion macros header.
`include "multichannel_frame_ring_buffer_top_defines.svh"

module mfrb_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              item_ready,
	input logic              result_valid,
	input logic              result_ready,
	input mfrb_pkg::result_t result
);

	import mfrb_pkg::*;

	// a burst's inner words are always real frames
	`MFRB_ASSERT_NEVER(a_inner_valid, result_valid && !result.last && !result.frame_valid, "inner burst word without a frame")

	// no new word while a burst is still running
	`MFRB_ASSERT(a_busy_in_burst, result_valid && !result.last |-> !item_ready, "input taken during a burst")

	// the next burst word follows at once and counts on by one
	`MFRB_ASSERT(a_burst_count, result_valid && result_ready && !result.last |=> result_valid && result.frames_done == DONE_W'($past(result.frames_done) + 1'b1), "burst count did not advance")

	// stalled result holds
	`MFRB_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "stalled result changed")

endmodule

bind multichannel_frame_ring_buffer_top mfrb_checker u_mfrb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
